### src/assert_macros.svh
// Assertion macros shared by the canvas line drawer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define CCLD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside of reset.
`define CCLD_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  `CCLD_ASSERT(name, clk, rst_n, !(cond), msg)

`endif

### src/ccld_pkg.sv
// ----------------------------------------------------------------------------
// ccld_pkg
// Types, constants and helpers shared by the canvas line drawer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ccld_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int CFG_SIZE_W = 7;
  localparam int CHAR_W     = 8;
  localparam int FIELD_W    = 6;
  localparam int SIZE_W     = 9;   // effective size, up to 127
  localparam int COORD_W    = 8;   // storage row / column, up to 255
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int STATUS_W   = 2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_SIZE_W-1:0] ROWS_RESET   = 7'd64;
  localparam logic [CFG_SIZE_W-1:0] COLS_RESET   = 7'd64;
  localparam logic [CHAR_W-1:0]     BLANK_RESET  = 8'd42;
  localparam logic [CHAR_W-1:0]     ASCEND_RESET = 8'd47;
  localparam logic [CHAR_W-1:0]     CROSS_RESET  = 8'd43;

  localparam logic [CHAR_W-1:0] CH_HORIZ = 8'd45;   // '-'
  localparam logic [CHAR_W-1:0] CH_VERT  = 8'd124;  // '|'
  localparam logic [CHAR_W-1:0] CH_DESC  = 8'd92;   // '\'

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS   = 3'd0,
    CFG_COLS   = 3'd1,
    CFG_BLANK  = 3'd2,
    CFG_ASCEND = 3'd3,
    CFG_CROSS  = 3'd4
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_SHAPE = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    LINE_HORIZ = 2'd0,
    LINE_VERT  = 2'd1,
    LINE_ASC   = 2'd2,
    LINE_DESC  = 2'd3
  } line_e;

  typedef enum logic [1:0] {
    STEP_HOLD = 2'd0,
    STEP_INC  = 2'd1,
    STEP_DEC  = 2'd2
  } step_e;

  typedef struct packed {
    logic [CFG_SIZE_W-1:0] rows;
    logic [CFG_SIZE_W-1:0] cols;
    logic [CHAR_W-1:0]     blank;
    logic [CHAR_W-1:0]     ascend;
    logic [CHAR_W-1:0]     cross_ch;
  } cfg_t;

  typedef struct packed {
    logic               is_read;
    status_e            status;
    line_e              line;
    step_e              row_step;
    step_e              col_step;
    logic [COORD_W-1:0] prow;
    logic [COORD_W-1:0] col;
    logic [LEN_W-1:0]   len;
  } cmd_t;

  // Clamp a size register to the range 1 .. maxv.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_SIZE_W-1:0] v,
                                                 input int maxv);
    logic [SIZE_W-1:0] wide;
    logic [SIZE_W-1:0] lim;
    wide = {{(SIZE_W-CFG_SIZE_W){1'b0}}, v};
    lim  = SIZE_W'(maxv);
    if (v == '0) begin
      return SIZE_W'(1);
    end else if (wide > lim) begin
      return lim;
    end
    return wide;
  endfunction

endpackage

`default_nettype wire

### src/ccld_if.sv
// ----------------------------------------------------------------------------
// ccld_in_if / ccld_out_if
// Valid/ready channels for draw and read requests and for their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccld_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [5:0] first_row;
  logic [5:0] first_col;
  logic [5:0] second_row;
  logic [5:0] second_col;

  modport source (output valid, kind, first_row, first_col, second_row, second_col,
                  input ready);
  modport sink   (input valid, kind, first_row, first_col, second_row, second_col,
                  output ready);
endinterface

interface ccld_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] cell_value;

  modport source (output valid, status, cell_value, input ready);
  modport sink   (input valid, status, cell_value, output ready);
endinterface

`default_nettype wire

### src/ccld_queue.sv
// ----------------------------------------------------------------------------
// ccld_queue
// Short command queue between the classifier and the drawing engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ccld_queue
  import ccld_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  wire  pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  `CCLD_ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni, push_i && full_o,
                     "command queue written while full")
  `CCLD_ASSERT_NEVER(a_queue_underflow, clk_i, rst_ni, pop_i && empty_o,
                     "command queue popped while empty")

endmodule

`default_nettype wire

### src/ccld_front.sv
// ----------------------------------------------------------------------------
// ccld_front
// Accept requests, check bounds and classify the line shape into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module ccld_front
  import ccld_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  ccld_in_if.sink in_ch,
  input  cfg_t    cfg_i,
  input  wire     clearing_i,
  input  wire     queue_full_i,
  output logic    push_o,
  output cmd_t    cmd_o
);

  logic [SIZE_W-1:0]  rows_eff, cols_eff;
  logic [SIZE_W-1:0]  r0, c0, r1, c1;
  logic [SIZE_W-1:0]  prow_full;
  logic               out0, out1;
  logic signed [FIELD_W:0] rise, run;
  logic [FIELD_W:0]   rise_abs, run_abs;
  logic               is_h, is_v, is_a, is_d;

  assign in_ch.ready = !queue_full_i && !clearing_i;
  assign push_o      = in_ch.valid && in_ch.ready;

  always_comb begin
    rows_eff = eff_size(cfg_i.rows, MAX_ROWS);
    cols_eff = eff_size(cfg_i.cols, MAX_COLS);
    r0 = SIZE_W'(in_ch.first_row);
    c0 = SIZE_W'(in_ch.first_col);
    r1 = SIZE_W'(in_ch.second_row);
    c1 = SIZE_W'(in_ch.second_col);

    out0 = (r0 >= rows_eff) || (c0 >= cols_eff);
    out1 = (r1 >= rows_eff) || (c1 >= cols_eff);

    rise = $signed({1'b0, in_ch.second_row}) - $signed({1'b0, in_ch.first_row});
    run  = $signed({1'b0, in_ch.second_col}) - $signed({1'b0, in_ch.first_col});
    rise_abs = rise[FIELD_W] ? -rise : rise;
    run_abs  = run[FIELD_W] ? -run : run;

    is_h = (rise == '0) && (run != '0);
    is_v = (run == '0) && (rise != '0);
    is_a = (rise != '0) && (rise == run);
    is_d = (rise != '0) && (rise == -run);

    // storage rows run top-down
    prow_full = rows_eff - SIZE_W'(1) - r0;

    cmd_o          = '0;
    cmd_o.is_read  = in_ch.kind;
    cmd_o.prow     = prow_full[COORD_W-1:0];
    cmd_o.col      = COORD_W'(in_ch.first_col);
    cmd_o.status   = ST_DONE;
    cmd_o.line     = LINE_HORIZ;
    cmd_o.row_step = STEP_HOLD;
    cmd_o.col_step = STEP_HOLD;
    cmd_o.len      = rise_abs[LEN_W-1:0];

    if (in_ch.kind) begin
      if (out0) begin
        cmd_o.status = ST_RANGE;
      end
    end else if (out0 || out1) begin
      cmd_o.status = ST_RANGE;
    end else begin
      // row up on the canvas is a lower storage row
      if (rise > 0) begin
        cmd_o.row_step = STEP_DEC;
      end else if (rise < 0) begin
        cmd_o.row_step = STEP_INC;
      end
      if (run > 0) begin
        cmd_o.col_step = STEP_INC;
      end else if (run < 0) begin
        cmd_o.col_step = STEP_DEC;
      end
      if (is_h) begin
        cmd_o.line = LINE_HORIZ;
        cmd_o.len  = run_abs[LEN_W-1:0];
      end else if (is_v) begin
        cmd_o.line = LINE_VERT;
      end else if (is_a) begin
        cmd_o.line = LINE_ASC;
      end else if (is_d) begin
        cmd_o.line = LINE_DESC;
      end else begin
        cmd_o.status = ST_SHAPE;
      end
    end
  end

endmodule

`default_nettype wire

### src/ccld_back.sv
// ----------------------------------------------------------------------------
// ccld_back
// Drawing engine: owns the canvas memory, clears it after reset, runs
// read-modify-write over each line's cells and reads single cells.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ccld_back
  import ccld_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  cfg_t             cfg_i,
  input  wire              queue_empty_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  output logic             clearing_o,
  ccld_out_if.source       out_ch
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_MOD   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [COORD_W-1:0] row_q, row_d;
  logic [COORD_W-1:0] col_q, col_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               is_read_q, is_read_d;
  line_e              line_q, line_d;
  step_e              rstep_q, rstep_d;
  step_e              cstep_q, cstep_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [CHAR_W-1:0]  res_value_q, res_value_d;
  logic               out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [CHAR_W-1:0]  out_value_q, out_value_d;

  logic [CHAR_W-1:0]  mem_q [DEPTH];
  logic [CHAR_W-1:0]  rd_data_q;
  logic [ADDR_W-1:0]  cell_addr;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic [CHAR_W-1:0]  mem_wdata;
  logic [CHAR_W-1:0]  line_char;

  assign cell_addr = ADDR_W'(row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q);
  assign clearing_o = (state_q == S_CLEAR);

  assign out_ch.valid      = out_valid_q;
  assign out_ch.status     = out_status_q;
  assign out_ch.cell_value = out_value_q;

  always_comb begin
    unique case (line_q)
      LINE_HORIZ: line_char = CH_HORIZ;
      LINE_VERT:  line_char = CH_VERT;
      LINE_ASC:   line_char = cfg_i.ascend;
      LINE_DESC:  line_char = CH_DESC;
      default:    line_char = CH_HORIZ;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    row_d        = row_q;
    col_d        = col_q;
    cnt_d        = cnt_q;
    len_d        = len_q;
    is_read_d    = is_read_q;
    line_d       = line_q;
    rstep_d      = rstep_q;
    cstep_d      = cstep_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && !out_ch.ready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    pop_o        = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = cell_addr;
    mem_wdata    = (rd_data_q == cfg_i.blank) ? line_char : cfg_i.cross_ch;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = BLANK_RESET;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!queue_empty_i) begin
          pop_o        = 1'b1;
          row_d        = cmd_i.prow;
          col_d        = cmd_i.col;
          len_d        = cmd_i.len;
          cnt_d        = '0;
          is_read_d    = cmd_i.is_read;
          line_d       = cmd_i.line;
          rstep_d      = cmd_i.row_step;
          cstep_d      = cmd_i.col_step;
          res_status_d = cmd_i.status;
          res_value_d  = '0;
          state_d      = (cmd_i.status == ST_DONE) ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        state_d = S_MOD;
      end
      S_MOD: begin
        if (is_read_q) begin
          res_value_d = rd_data_q;
          state_d     = S_DONE;
        end else begin
          mem_we = 1'b1;
          if (cnt_q == len_q) begin
            state_d = S_DONE;
          end else begin
            cnt_d   = cnt_q + LEN_W'(1);
            state_d = S_READ;
            case (rstep_q)
              STEP_INC: row_d = row_q + COORD_W'(1);
              STEP_DEC: row_d = row_q - COORD_W'(1);
              default:  row_d = row_q;
            endcase
            case (cstep_q)
              STEP_INC: col_d = col_q + COORD_W'(1);
              STEP_DEC: col_d = col_q - COORD_W'(1);
              default:  col_d = col_q;
            endcase
          end
        end
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    col_q        <= col_d;
    cnt_q        <= cnt_d;
    len_q        <= len_d;
    is_read_q    <= is_read_d;
    line_q       <= line_d;
    rstep_q      <= rstep_d;
    cstep_q      <= cstep_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_addr];
  end

  `CCLD_ASSERT(a_no_result_in_clear, clk_i, rst_ni,
               state_q == S_CLEAR |-> !out_valid_q, "result shown during clearing pass")
  `CCLD_ASSERT(a_cnt_bound, clk_i, rst_ni,
               (state_q == S_READ || state_q == S_MOD) |-> cnt_q <= len_q,
               "cell counter ran past line length")
  `CCLD_ASSERT(a_last_cell_done, clk_i, rst_ni,
               (state_q == S_MOD && cnt_q == len_q) |=> state_q == S_DONE,
               "line did not finish after its last cell")

endmodule

`default_nettype wire

### src/char_canvas_line_drawer_core.sv
// Character canvas line drawer. Draw and read requests enter a two-entry command
// queue after a bounds and shape check, so a new request is taken while the
// engine works and while a finished result waits in the output register. The
// engine does a read-modify-write on the single-port canvas memory, with a read
// state and a modify state for each cell; a line has up to 64 cells.
// After reset the engine sweeps all MAX_ROWS*MAX_COLS cells (4096 by default)
// to the reset blank character, one cell a cycle; no request is taken during
// the sweep, configuration writes are. Rows count from the bottom; status 1
// flags a shape other than a horizontal, vertical or 45-degree line, status 2
// a coordinate outside the canvas.
// ----------------------------------------------------------------------------
// char_canvas_line_drawer_core
// Top level: configuration registers, request classifier, command queue and
// drawing engine.
// ----------------------------------------------------------------------------
`default_nettype none

module char_canvas_line_drawer_core
  import ccld_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  ccld_in_if.sink               in_ch,
  ccld_out_if.source            out_ch,
  input  wire                   cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [CHAR_W-1:0]     cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  cmd_t front_cmd, queue_cmd;
  logic push, pop, queue_full, queue_empty, clearing;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS:   cfg_d.rows     = cfg_data_i[CFG_SIZE_W-1:0];
        CFG_COLS:   cfg_d.cols     = cfg_data_i[CFG_SIZE_W-1:0];
        CFG_BLANK:  cfg_d.blank    = cfg_data_i;
        CFG_ASCEND: cfg_d.ascend   = cfg_data_i;
        CFG_CROSS:  cfg_d.cross_ch = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows     <= ROWS_RESET;
      cfg_q.cols     <= COLS_RESET;
      cfg_q.blank    <= BLANK_RESET;
      cfg_q.ascend   <= ASCEND_RESET;
      cfg_q.cross_ch <= CROSS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ccld_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .in_ch        (in_ch),
    .cfg_i        (cfg_q),
    .clearing_i   (clearing),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  ccld_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .empty_o (queue_empty)
  );

  ccld_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .queue_empty_i (queue_empty),
    .cmd_i         (queue_cmd),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

### sim/tb_char_canvas_line_drawer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_canvas_line_drawer_core
// Self-checking bench for the character canvas line drawer. A local canvas
// predictor follows every accepted draw or read request and queues the
// expected status and cell value. Results are checked in order. Stimulus
// runs directed line shapes and bounds cases first, then random phases under
// several canvas sizes and character sets, with random stalls on both
// channels.
// ----------------------------------------------------------------------------

module tb_char_canvas_line_drawer_core;
  import ccld_pkg::*;

  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 3;
  localparam int DRAIN_CYCLES   = 8;
  localparam int END_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int SHOWN_ERRORS   = 10;

  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] r0;
    logic [FIELD_W-1:0] c0;
    logic [FIELD_W-1:0] r1;
    logic [FIELD_W-1:0] c1;
  } canvas_req_t;

  typedef struct packed {
    status_e            status;
    logic [CHAR_W-1:0]  cell_value;
  } cell_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CHAR_W-1:0]    cfg_data_i;

  ccld_in_if  req_ch ();
  ccld_out_if res_ch ();

  char_canvas_line_drawer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (req_ch),
    .out_ch     (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state: canvas and register copies
  logic [CHAR_W-1:0]     canvas_mem [DEF_MAX_ROWS][DEF_MAX_COLS];
  logic [CFG_SIZE_W-1:0] cfg_rows;
  logic [CFG_SIZE_W-1:0] cfg_cols;
  logic [CHAR_W-1:0]     cfg_blank;
  logic [CHAR_W-1:0]     cfg_ascend;
  logic [CHAR_W-1:0]     cfg_cross;

  cell_result_t pending_results [$];

  int  error_count;
  int  results_checked;
  int  requests_sent;
  int  settings_count;
  int  lines_drawn;
  int  cells_read;
  int  shape_rejects;
  int  range_rejects;
  int  gap_ahead;
  int  ready_hold;
  int  quiet_cycles;
  bit  idle_off;

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic int usable_size(input logic [CFG_SIZE_W-1:0] v, input int limit);
    if (v == '0) return 1;
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  // Mostly short gaps, a few long ones; none while idling is switched off.
  function automatic int pick_gap();
    int p;
    if (idle_off) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Apply one request to the canvas copy and return the result it causes.
  function automatic cell_result_t canvas_apply(input canvas_req_t rq);
    cell_result_t      res;
    logic [CHAR_W-1:0] line_ch;
    int rows, cols, r0, c0, r1, c1, rise, run, dr, dc, len, k, srow, col;
    rows = usable_size(cfg_rows, DEF_MAX_ROWS);
    cols = usable_size(cfg_cols, DEF_MAX_COLS);
    r0 = int'(rq.r0);
    c0 = int'(rq.c0);
    r1 = int'(rq.r1);
    c1 = int'(rq.c1);
    res.status = ST_DONE;
    res.cell_value = '0;
    if (rq.kind == KIND_READ) begin
      if (r0 >= rows || c0 >= cols) begin
        res.status = ST_RANGE;
      end else begin
        res.cell_value = canvas_mem[rows - 1 - r0][c0];
      end
      return res;
    end
    // Range check wins over the shape check
    if (r0 >= rows || r1 >= rows || c0 >= cols || c1 >= cols) begin
      res.status = ST_RANGE;
      return res;
    end
    rise = r1 - r0;
    run  = c1 - c0;
    dr = (rise > 0) ? 1 : ((rise < 0) ? -1 : 0);
    dc = (run > 0) ? 1 : ((run < 0) ? -1 : 0);
    len = (rise < 0) ? -rise : rise;
    if (len == 0) len = (run < 0) ? -run : run;
    if (rise == 0 && run != 0) begin
      line_ch = CH_HORIZ;
    end else if (run == 0 && rise != 0) begin
      line_ch = CH_VERT;
    end else if (rise != 0 && rise == run) begin
      line_ch = cfg_ascend;
    end else if (rise != 0 && rise == -run) begin
      line_ch = CH_DESC;
    end else begin
      res.status = ST_SHAPE;
      return res;
    end
    for (k = 0; k <= len; k++) begin
      srow = rows - 1 - (r0 + k * dr);
      col  = c0 + k * dc;
      if (canvas_mem[srow][col] == cfg_blank) begin
        canvas_mem[srow][col] = line_ch;
      end else begin
        canvas_mem[srow][col] = cfg_cross;
      end
    end
    return res;
  endfunction

  // Line of the given shape inside the current canvas; a zero span gives a point.
  function automatic canvas_req_t random_line(input line_e shape);
    canvas_req_t rq;
    int rows, cols, lim, span, r, c;
    rows = usable_size(cfg_rows, DEF_MAX_ROWS);
    cols = usable_size(cfg_cols, DEF_MAX_COLS);
    rq.kind = KIND_DRAW;
    rq.r0 = FIELD_W'($urandom_range(0, rows - 1));
    rq.c0 = FIELD_W'($urandom_range(0, cols - 1));
    rq.r1 = rq.r0;
    rq.c1 = rq.c0;
    case (shape)
      LINE_HORIZ: rq.c1 = FIELD_W'($urandom_range(0, cols - 1));
      LINE_VERT:  rq.r1 = FIELD_W'($urandom_range(0, rows - 1));
      default: begin
        lim  = (rows < cols) ? rows : cols;
        span = $urandom_range(0, lim - 1);
        r = $urandom_range(0, rows - 1 - span);
        c = $urandom_range(0, cols - 1 - span);
        if (shape == LINE_ASC) begin
          rq.r0 = FIELD_W'(r);
          rq.r1 = FIELD_W'(r + span);
        end else begin
          rq.r0 = FIELD_W'(r + span);
          rq.r1 = FIELD_W'(r);
        end
        rq.c0 = FIELD_W'(c);
        rq.c1 = FIELD_W'(c + span);
        if ($urandom_range(0, 1) == 1) begin
          rq = '{kind: KIND_DRAW, r0: rq.r1, c0: rq.c1, r1: rq.r0, c1: rq.c0};
        end
      end
    endcase
    return rq;
  endfunction

  task automatic report_failure(input string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) $display("%0t: MISMATCH %s", $realtime, msg);
  endtask

  // Send one request, record its expected result at the accepting edge.
  task automatic issue_request(input canvas_req_t rq);
    cell_result_t want;
    repeat (gap_ahead) @(posedge clk_i);
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= rq.kind;
    req_ch.first_row  <= rq.r0;
    req_ch.first_col  <= rq.c0;
    req_ch.second_row <= rq.r1;
    req_ch.second_col <= rq.c1;
    do @(posedge clk_i); while (!req_ch.ready);
    want = canvas_apply(rq);
    pending_results.push_back(want);
    requests_sent++;
    case (want.status)
      ST_SHAPE: shape_rejects++;
      ST_RANGE: range_rejects++;
      default: begin
        if (rq.kind == KIND_READ) cells_read++;
        else lines_drawn++;
      end
    endcase
    gap_ahead = pick_gap();
    if (gap_ahead != 0) req_ch.valid <= 1'b0;
  endtask

  task automatic draw(input int r0, input int c0, input int r1, input int c1);
    issue_request('{kind: KIND_DRAW, r0: FIELD_W'(r0), c0: FIELD_W'(c0),
                    r1: FIELD_W'(r1), c1: FIELD_W'(c1)});
  endtask

  // Unused endpoint fields carry random bits.
  task automatic read_cell(input int r, input int c);
    issue_request('{kind: KIND_READ, r0: FIELD_W'(r), c0: FIELD_W'(c),
                    r1: FIELD_W'($urandom), c1: FIELD_W'($urandom)});
  endtask

  // Drop valid and wait until every expected result is in.
  task automatic settle();
    if (gap_ahead == 0) req_ch.valid <= 1'b0;
    gap_ahead = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAR_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ROWS:   cfg_rows   = data[CFG_SIZE_W-1:0];
      CFG_COLS:   cfg_cols   = data[CFG_SIZE_W-1:0];
      CFG_BLANK:  cfg_blank  = data;
      CFG_ASCEND: cfg_ascend = data;
      CFG_CROSS:  cfg_cross  = data;
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [CHAR_W-1:0] rows_v, input logic [CHAR_W-1:0] cols_v,
                                input logic [CHAR_W-1:0] blank_v,
                                input logic [CHAR_W-1:0] ascend_v,
                                input logic [CHAR_W-1:0] cross_v);
    settle();
    put_reg(CFG_ROWS, rows_v);
    put_reg(CFG_COLS, cols_v);
    put_reg(CFG_BLANK, blank_v);
    put_reg(CFG_ASCEND, ascend_v);
    put_reg(CFG_CROSS, cross_v);
    // Indexes past the last register must be ignored
    put_reg(CFG_IDX_W'(CFG_CROSS) + CFG_IDX_W'($urandom_range(1, 3)), CHAR_W'($urandom));
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  task automatic run_phase(input int count, input bit calm);
    canvas_req_t rq;
    int          i, p;
    idle_off = calm;
    for (i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      if (p < 55) begin
        rq = random_line(line_e'($urandom_range(0, 3)));
      end else if (p < 75) begin
        rq = '{kind: KIND_READ,
               r0: FIELD_W'($urandom_range(0, usable_size(cfg_rows, DEF_MAX_ROWS))),
               c0: FIELD_W'($urandom_range(0, usable_size(cfg_cols, DEF_MAX_COLS))),
               r1: FIELD_W'($urandom), c1: FIELD_W'($urandom)};
      end else if (p < 85) begin
        // Break a diagonal by one column
        rq = random_line(($urandom_range(0, 1) == 1) ? LINE_ASC : LINE_DESC);
        rq.c1 = rq.c1 ^ FIELD_W'(1);
      end else begin
        rq = canvas_req_t'(25'($urandom));
      end
      issue_request(rq);
    end
    idle_off = 1'b0;
  endtask

  task automatic test_line_shapes();
    read_cell(0, 0);
    read_cell(63, 63);
    draw(10, 20, 10, 5);     // horizontal, right to left
    draw(63, 0, 63, 63);     // full top row
    draw(40, 7, 12, 7);      // vertical, downward
    draw(0, 0, 63, 0);       // full left column
    draw(0, 0, 63, 63);      // ascending, full canvas
    draw(30, 40, 20, 30);    // ascending, drawn backward
    draw(63, 0, 0, 63);      // descending, full canvas
    draw(5, 20, 15, 10);     // descending, drawn backward
    draw(31, 0, 31, 63);     // crosses both diagonals
    draw(9, 9, 9, 9);        // single point
    draw(0, 0, 2, 1);        // slope that is not 45 degrees
    read_cell(31, 31);
    read_cell(31, 32);
    read_cell(10, 12);
    read_cell(12, 7);
    read_cell(40, 7);
    read_cell(10, 15);
    read_cell(0, 0);
    read_cell(63, 63);
  endtask

  task automatic test_canvas_bounds();
    write_settings(8'h85, 8'd9, BLANK_RESET, ASCEND_RESET, CROSS_RESET);
    draw(5, 0, 5, 3);        // row just past the canvas
    draw(0, 8, 0, 9);        // column just past the canvas
    draw(7, 0, 9, 5);        // outside and badly shaped
    draw(4, 0, 0, 4);
    read_cell(4, 8);
    read_cell(5, 0);
    read_cell(0, 9);
    write_settings(8'h80, 8'h00, BLANK_RESET, ASCEND_RESET, CROSS_RESET);
    draw(0, 0, 0, 0);
    read_cell(0, 0);
    read_cell(0, 1);
  endtask

  task automatic test_register_extremes();
    write_settings(8'hFF, 8'd40, 8'd0, 8'd255, 8'd128);
    run_phase(300, 1'b1);
    write_settings(8'd1, 8'd64, CH_HORIZ, CH_DESC, 8'd255);
    run_phase(150, 1'b0);
    write_settings(8'd64, 8'h81, CH_VERT, 8'd0, CH_VERT);
    run_phase(150, 1'b0);
    write_settings(8'd0, 8'd0, 8'd255, ASCEND_RESET, 8'd0);
    run_phase(40, 1'b0);
  endtask

  task automatic test_random_drawing();
    int n;
    write_settings(8'd64, 8'd64, BLANK_RESET, ASCEND_RESET, CROSS_RESET);
    run_phase(320, 1'b0);
    for (n = 0; n < 4; n++) begin
      write_settings(($urandom_range(0, 1) == 1) ? CHAR_W'($urandom_range(1, 64))
                                                 : CHAR_W'($urandom),
                     ($urandom_range(0, 1) == 1) ? CHAR_W'($urandom_range(1, 64))
                                                 : CHAR_W'($urandom),
                     CHAR_W'($urandom), CHAR_W'($urandom), CHAR_W'($urandom));
      run_phase(240, n == 2);
    end
  endtask

  // Output side: random backpressure
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      res_ch.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else begin
      res_ch.ready <= 1'b1;
      ready_hold   <= pick_gap();
    end
  end

  always @(posedge clk_i) begin : check_results
    cell_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_failure($sformatf("result with nothing expected: status %0d cell %0d",
                                 res_ch.status, res_ch.cell_value));
      end else begin
        want = pending_results.pop_front();
        if (res_ch.status !== want.status) begin
          report_failure($sformatf("status expected %0d actual %0d",
                                   want.status, res_ch.status));
        end
        if (res_ch.cell_value !== want.cell_value) begin
          report_failure($sformatf("cell_value expected %0d actual %0d",
                                   want.cell_value, res_ch.cell_value));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    req_ch.valid      = 1'b0;
    req_ch.kind       = KIND_DRAW;
    req_ch.first_row  = '0;
    req_ch.first_col  = '0;
    req_ch.second_row = '0;
    req_ch.second_col = '0;
    res_ch.ready      = 1'b0;
    ready_hold        = 0;
    quiet_cycles      = 0;
    gap_ahead         = 0;
    idle_off          = 1'b0;
    cfg_rows          = ROWS_RESET;
    cfg_cols          = COLS_RESET;
    cfg_blank         = BLANK_RESET;
    cfg_ascend        = ASCEND_RESET;
    cfg_cross         = CROSS_RESET;
    foreach (canvas_mem[r, c]) canvas_mem[r][c] = BLANK_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_line_shapes();
    test_canvas_bounds();
    test_register_extremes();
    test_random_drawing();

    settle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", pending_results.size()));
    end
    $display("Checked %0d results from %0d requests over %0d register settings.",
             results_checked, requests_sent, settings_count + 1);
    $display("Lines drawn %0d, cells read %0d, shape rejects %0d, range rejects %0d.",
             lines_drawn, cells_read, shape_rejects, range_rejects);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
